@@ design/vn_pkg.sv @@
// Shared types and constants for the vector normalization pipeline.
`default_nettype none
package vn_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic        [31:0] length;
        logic               zero_length;
    } out_t;

    typedef struct packed {
        logic [2:0]  sign;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sqrt_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] nq;
    } lane_t;

    typedef struct packed {
        logic [2:0]  sign;
        logic [31:0] len;
        lane_t [2:0] lane;
    } div_t;

endpackage
`default_nettype wire

@@ design/vn_square.sv @@
// Front stages: component magnitudes, squares and the sum of squares.
`default_nettype none
module vn_square (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          mode,
    input  wire logic          in_valid,
    input  vn_pkg::in_t        in_data,
    output logic               out_valid,
    output vn_pkg::sqrt_t      out_data
);
    import vn_pkg::*;

    logic [2:0]  a_valid_reg;
    logic [2:0]  a_sign_reg;
    logic [31:0] a_mag_reg [3];
    logic [2:0]  b_sign_reg;
    logic [31:0] b_mag_reg [3];
    logic [63:0] b_sq_reg  [3];
    sqrt_t       c_reg;
    logic [31:0] z_raw;
    logic [31:0] mag_next [3];

    assign z_raw = mode ? in_data.vec_z : 32'd0;

    always_comb
    begin
        mag_next[0] = in_data.vec_x[31] ? 32'(-in_data.vec_x) : in_data.vec_x;
        mag_next[1] = in_data.vec_y[31] ? 32'(-in_data.vec_y) : in_data.vec_y;
        mag_next[2] = z_raw[31] ? 32'(-z_raw) : z_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= '0;
        else if (en)
            a_valid_reg <= {a_valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sign_reg <= {z_raw[31], in_data.vec_y[31], in_data.vec_x[31]};
            for (int i = 0; i < 3; i++)
            begin
                a_mag_reg[i] <= mag_next[i];
                b_mag_reg[i] <= a_mag_reg[i];
                b_sq_reg[i]  <= 64'(a_mag_reg[i]) * 64'(a_mag_reg[i]);
            end
            b_sign_reg   <= a_sign_reg;
            c_reg.sign   <= b_sign_reg;
            c_reg.mag_x  <= b_mag_reg[0];
            c_reg.mag_y  <= b_mag_reg[1];
            c_reg.mag_z  <= b_mag_reg[2];
            c_reg.rem    <= '0;
            c_reg.root   <= '0;
            c_reg.rad    <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
        end
    end

    assign out_valid = a_valid_reg[2];
    assign out_data  = c_reg;
endmodule
`default_nettype wire

@@ design/vn_sqrt_cell.sv @@
// One square root cell: settles one bit of the root per stage.
`default_nettype none
module vn_sqrt_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  vn_pkg::sqrt_t      in_data,
    output logic               out_valid,
    output vn_pkg::sqrt_t      out_data
);
    import vn_pkg::*;

    logic        valid_reg;
    sqrt_t       data_reg;
    sqrt_t       data_next;
    logic [35:0] trial_rem;
    logic [35:0] trial_sub;

    always_comb
    begin
        trial_rem = {in_data.rem, in_data.rad[63:62]};
        trial_sub = {2'b00, in_data.root, 2'b01};
        data_next = in_data;
        data_next.rad = {in_data.rad[61:0], 2'b00};
        if (trial_rem >= trial_sub)
        begin
            data_next.rem  = 34'(trial_rem - trial_sub);
            data_next.root = {in_data.root[30:0], 1'b1};
        end
        else
        begin
            data_next.rem  = trial_rem[33:0];
            data_next.root = {in_data.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

@@ design/vn_div_cell.sv @@
// One divider cell: one quotient bit for each of the three lanes.
`default_nettype none
module vn_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  vn_pkg::div_t       in_data,
    output logic               out_valid,
    output vn_pkg::div_t       out_data
);
    import vn_pkg::*;

    logic        valid_reg;
    div_t        data_reg;
    div_t        data_next;
    logic [32:0] shifted [3];

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = {in_data.lane[i].rem, in_data.lane[i].nq[30]};
            if (shifted[i] >= {1'b0, in_data.len})
            begin
                data_next.lane[i].rem = 32'(shifted[i] - {1'b0, in_data.len});
                data_next.lane[i].nq  = {in_data.lane[i].nq[29:0], 1'b1};
            end
            else
            begin
                data_next.lane[i].rem = shifted[i][31:0];
                data_next.lane[i].nq  = {in_data.lane[i].nq[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

@@ design/vector_normalize.sv @@
// Throughput: one transaction per cycle unless the output stalls; every stage is a
// register, so a new vector enters each cycle while the square root and divider
// cells work on older ones.
// The whole pipeline holds only while a result waits on the output and out_ready is low.
// Reset (rst_n, asynchronous, active low) clears all valid bits and sets 3D mode.
`default_nettype none
module vector_normalize (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  vn_pkg::in_t        in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output vn_pkg::out_t       out_data
);
    import vn_pkg::*;

    // Pipeline advance: everything moves unless the output transaction is stalled.
    logic  en;
    logic  mode_reg;

    logic  sq_valid [SQRT_STEPS+1];
    sqrt_t sq_data  [SQRT_STEPS+1];
    logic  dv_valid [DIV_STEPS+1];
    div_t  dv_data  [DIV_STEPS+1];

    logic  prep_valid_reg;
    div_t  prep_reg;
    div_t  prep_next;
    logic  out_valid_reg;
    out_t  out_reg;
    out_t  out_next;
    logic [61:0] numer [3];
    logic [31:0] mags  [3];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Mode register; the user must write it only while the pipeline is empty, and the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    vn_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (mode_reg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (sq_valid[0]),
        .out_data  (sq_data[0])
    );

    // Digit-by-digit square root: one root bit per cell, 32 cells.
    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        vn_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[g]),
            .in_data   (sq_data[g]),
            .out_valid (sq_valid[g+1]),
            .out_data  (sq_data[g+1])
        );
    end

    // Dividend is |c| * 2^30 plus half the length, for round to nearest.
    // The quotient never exceeds 2^30, so the top 31 bits start below the divisor.
    always_comb
    begin
        mags[0] = sq_data[SQRT_STEPS].mag_x;
        mags[1] = sq_data[SQRT_STEPS].mag_y;
        mags[2] = sq_data[SQRT_STEPS].mag_z;
        prep_next.sign = sq_data[SQRT_STEPS].sign;
        prep_next.len  = sq_data[SQRT_STEPS].root;
        for (int i = 0; i < 3; i++)
        begin
            numer[i] = {mags[i], 30'd0} + 62'(sq_data[SQRT_STEPS].root[31:1]);
            prep_next.lane[i].rem = {1'b0, numer[i][61:31]};
            prep_next.lane[i].nq  = numer[i][30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (en)
            prep_valid_reg <= sq_valid[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    assign dv_valid[0] = prep_valid_reg;
    assign dv_data[0]  = prep_reg;

    // Restoring division, three components side by side, one quotient bit per cell.
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        vn_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[g]),
            .in_data   (dv_data[g]),
            .out_valid (dv_valid[g+1]),
            .out_data  (dv_data[g+1])
        );
    end

    // Sign restore and the zero-length case. A zero length leaves garbage in the
    // quotients, so the three unit fields are forced to zero here.
    always_comb
    begin
        out_next.zero_length = (dv_data[DIV_STEPS].len == 32'd0);
        out_next.length      = dv_data[DIV_STEPS].len;
        out_next.unit_x = dv_data[DIV_STEPS].sign[0]
                        ? -$signed({1'b0, dv_data[DIV_STEPS].lane[0].nq})
                        :  $signed({1'b0, dv_data[DIV_STEPS].lane[0].nq});
        out_next.unit_y = dv_data[DIV_STEPS].sign[1]
                        ? -$signed({1'b0, dv_data[DIV_STEPS].lane[1].nq})
                        :  $signed({1'b0, dv_data[DIV_STEPS].lane[1].nq});
        out_next.unit_z = dv_data[DIV_STEPS].sign[2]
                        ? -$signed({1'b0, dv_data[DIV_STEPS].lane[2].nq})
                        :  $signed({1'b0, dv_data[DIV_STEPS].lane[2].nq});
        if (out_next.zero_length)
        begin
            out_next.unit_x = '0;
            out_next.unit_y = '0;
            out_next.unit_z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

@@ design/vn_check.sv @@
// Port-level checker for the vector normalizer and its bind statement.
`default_nettype none
module vn_check (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_ready,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input vn_pkg::out_t       out_data
);
    import vn_pkg::*;

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_length |->
            out_data.unit_x == 0 && out_data.unit_y == 0 &&
            out_data.unit_z == 0 && out_data.length == 0)
        else $error("zero-length result carries nonzero fields");

    a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.zero_length |-> out_data.length != 0)
        else $error("zero length without flag");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.unit_x <= 32'sh4000_0000 &&
                      out_data.unit_x >= -32'sh4000_0000)
        else $error("unit_x out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output is empty");
endmodule

bind vector_normalize vn_check u_vn_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

@@ sim/tb_vector_normalize.sv @@
// Self-checking testbench for the fixed-point vector normalization pipeline.
`default_nettype none
module tb_vector_normalize;
    timeunit 1ns;
    timeprecision 1ps;
    import vn_pkg::*;

    localparam int LATENCY     = 68;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic MODE_2D   = 1'b0;
    localparam logic MODE_3D   = 1'b1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    vector_normalize u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Vectors waiting to be driven, and results predicted for accepted vectors.
    in_t  pending_vecs[$];
    out_t expected_units[$];

    // Predictor's copy of the mode register.
    logic mode_3d;

    int   errors;
    int   cycles;
    int   vecs_sent;
    int   units_seen;
    int   zero_seen;
    int   send_gap;
    int   recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Magnitude of a two's complement component, 0 .. 2^31.
    function automatic logic [63:0] comp_mag(input logic [31:0] c);
        return c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
    endfunction

    // Floor of the square root of the 64-bit sum of squares, digit by digit.
    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = n;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Signed Q2.30 quotient, rounded to nearest with ties away from zero.
    function automatic logic [31:0] unit_of(input logic [31:0] c, input logic [63:0] len);
        logic [63:0] q;
        q = ((comp_mag(c) << 30) + (len >> 1)) / len;
        if (c[31])
            q = -q;
        return q[31:0];
    endfunction

    // Predicts the result for one vector under the current mode.
    function automatic out_t normalize_vec(input in_t v);
        out_t        r;
        logic [31:0] z;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] az;
        logic [63:0] len;
        z   = mode_3d ? v.vec_z : 32'd0;
        ax  = comp_mag(v.vec_x);
        ay  = comp_mag(v.vec_y);
        az  = comp_mag(z);
        len = floor_root(ax * ax + ay * ay + az * az);
        r   = '0;
        if (len == 0)
            r.zero_length = 1'b1;
        else
        begin
            r.unit_x = unit_of(v.vec_x, len);
            r.unit_y = unit_of(v.vec_y, len);
            r.unit_z = unit_of(z, len);
            r.length = len[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_comp();
        unique case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(0, 15) - 8;
            4: return $urandom_range(0, 2047) - 1024;
            5: return {{12{1'b0}}, 20'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        in_t v;
        v.vec_x = x;
        v.vec_y = y;
        v.vec_z = z;
        pending_vecs.push_back(v);
    endtask

    // Lets everything in flight drain, then writes the mode register while idle.
    // The idle test is made at the falling edge, once the driver has settled.
    task automatic set_mode(input logic m);
        while (pending_vecs.size() != 0 || expected_units.size() != 0 || in_valid)
            @(negedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_3d  = m;
    endtask

    // Driver: takes vectors from the queue with a random gap after each one.
    // The prediction is made at acceptance so it sees the mode in effect.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_units.push_back(normalize_vec(in_data));
                vecs_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0 || pending_vecs.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_vecs.pop_front();
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                end
            end
        end
    end

    // Monitor: random back-pressure on the result channel, field-by-field compare.
    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_u;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            cycles++;
            if (out_valid && out_ready)
            begin
                units_seen++;
                if (expected_units.size() == 0)
                begin
                    $display("%0t: unexpected transaction %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    exp_u = expected_units.pop_front();
                    if (out_data.zero_length)
                        zero_seen++;
                    if (out_data.unit_x !== exp_u.unit_x)
                        $display("%0t: unit_x expected %h actual %h", $time, exp_u.unit_x,
                                 out_data.unit_x);
                    if (out_data.unit_y !== exp_u.unit_y)
                        $display("%0t: unit_y expected %h actual %h", $time, exp_u.unit_y,
                                 out_data.unit_y);
                    if (out_data.unit_z !== exp_u.unit_z)
                        $display("%0t: unit_z expected %h actual %h", $time, exp_u.unit_z,
                                 out_data.unit_z);
                    if (out_data.length !== exp_u.length)
                        $display("%0t: length expected %h actual %h", $time, exp_u.length,
                                 out_data.length);
                    if (out_data.zero_length !== exp_u.zero_length)
                        $display("%0t: zero_length expected %b actual %b", $time,
                                 exp_u.zero_length, out_data.zero_length);
                    if (out_data !== exp_u)
                        errors++;
                end
            end
            // Each gap is drawn once the previous one runs out; some phases never stall.
            if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("vector_normalize: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = 1'b0;
        mode_3d   = MODE_3D;
        errors    = 0;
        cycles    = 0;
        vecs_sent = 0;
        units_seen = 0;
        zero_seen = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed vectors in the reset (3D) mode: zero vector, extremes, axes.
        queue_vec(0, 0, 0);
        queue_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_vec(32'h8000_0000, 0, 0);
        queue_vec(0, 32'h7fff_ffff, 0);
        queue_vec(0, 0, 32'h8000_0000);
        queue_vec(1, 0, 0);
        queue_vec(32'hffff_ffff, 1, 1);
        queue_vec(3, 4, 0);
        queue_vec(32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
        queue_vec(0, 0, 1);
        queue_vec(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);

        // Random part: mostly 3D, then 2D with a nonzero z that must be ignored, then 3D again.
        for (int i = 0; i < 1000; i++)
            queue_vec(rand_comp(), rand_comp(), rand_comp());
        set_mode(MODE_2D);
        queue_vec(0, 0, 32'h7fff_ffff);
        queue_vec(32'h8000_0000, 32'h8000_0000, 5);
        queue_vec(7, 32'hffff_fff9, 32'h8000_0000);
        for (int i = 0; i < 700; i++)
            queue_vec(rand_comp(), rand_comp(), rand_comp());
        set_mode(MODE_3D);
        for (int i = 0; i < 300; i++)
            queue_vec(rand_comp(), rand_comp(), rand_comp());

        while (pending_vecs.size() != 0 || expected_units.size() != 0 || in_valid)
            @(negedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d vectors through 3D, 2D and back to 3D mode under random stalls;",
                 vecs_sent);
        $display("checked %0d results, %0d of them zero-length.", units_seen, zero_seen);
        if (errors == 0 && expected_units.size() == 0)
            $display("vector_normalize: match");
        else
            $display("vector_normalize: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
